>>> rtl/cpps_pkg.sv
// cpps_pkg: shared widths, constants and types for the complex power peak search
// used by cpps_power, cpps_accum and complex_power_peak_search_core
package cpps_pkg;

   // sample and power widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned POWER_W  = 32;
   localparam int unsigned PACKED_W = 31;
   localparam int unsigned INDEX_W  = 11;

   // samples per block and the counter that spans one block
   localparam int unsigned BLOCK_LEN = 2048;
   localparam int unsigned COUNT_W   = $clog2(BLOCK_LEN);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(BLOCK_LEN - 1);

   // arithmetic shift applied to each power before it is summed
   localparam int unsigned SUM_SHIFT = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [POWER_W-1:0]         power_type;

   // status from the accumulator back to the pipeline control
   typedef struct packed {
      logic hold;        // end-of-block transaction blocked by a waiting result
   } accum_status_type;

endpackage

>>> rtl/cpps_power.sv
// cpps_power: input register, squaring multipliers and power adder, three stages
// depends on cpps_pkg
module cpps_power
   import cpps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       in_valid,
   input  sample_type in_i,
   input  sample_type in_q,
   output logic       pw_valid,
   output power_type  pw
);

   logic       a_valid_ff, a_valid_in;
   sample_type a_i_ff, a_q_ff;
   logic       b_valid_ff, b_valid_in;
   power_type  b_pi_ff, b_pq_ff;
   logic       c_valid_ff, c_valid_in;
   power_type  c_pw_ff;
   logic signed [2*SAMPLE_W-1:0] prod_i, prod_q;

   // stage valids move only when the pipeline advances
   assign a_valid_in = advance ? in_valid   : a_valid_ff;
   assign b_valid_in = advance ? a_valid_ff : b_valid_ff;
   assign c_valid_in = advance ? b_valid_ff : c_valid_ff;

   // squares of the registered sample
   assign prod_i = a_i_ff * a_i_ff;
   assign prod_q = a_q_ff * a_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         a_i_ff  <= in_i;
         a_q_ff  <= in_q;
         b_pi_ff <= power_type'(prod_i);
         b_pq_ff <= power_type'(prod_q);
         c_pw_ff <= b_pi_ff + b_pq_ff;
      end
   end

   assign pw_valid = c_valid_ff;
   assign pw       = c_pw_ff;

endmodule

>>> rtl/cpps_accum.sv
// cpps_accum: block counter, running peak, running sum and the result register
// depends on cpps_pkg
module cpps_accum
   import cpps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    pw_valid,
   input  power_type               pw,
   output accum_status_type        status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PACKED_W-1:0]     rsp_peak_packed,
   output logic [INDEX_W-1:0]      rsp_peak_index,
   output logic signed [POWER_W-1:0] rsp_power_sum
);

   logic [COUNT_W-1:0] count_ff, count_in;
   power_type          peak_ff, peak_in;
   power_type          sum_ff, sum_in;
   logic               out_valid_ff, out_valid_in;
   logic [PACKED_W-1:0] out_packed_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   power_type           out_sum_ff;

   logic        take, last, load;
   logic [31:0] count_ext;
   power_type   packed_word, peak_next, sum_next, pw_shift;

   // a transaction reaches the accumulator when the pipeline advances
   assign take = advance && pw_valid;
   assign last = (count_ff == COUNT_LAST);
   assign load = take && last;

   // end of block cannot land while the result register is still full
   assign status.hold = pw_valid && last && out_valid_ff && !rsp_ready;

   // pack truncated power with the sample index
   assign count_ext   = 32'(count_ff);
   assign packed_word = {pw[POWER_W-1:INDEX_W], count_ext[INDEX_W-1:0]};
   assign pw_shift    = power_type'($signed(pw) >>> SUM_SHIFT);

   // signed maximum, later sample wins a tie
   assign peak_next = ($signed(packed_word) >= $signed(peak_ff)) ? packed_word : peak_ff;
   assign sum_next  = sum_ff + pw_shift;

   always_comb begin
      count_in = count_ff;
      peak_in  = peak_ff;
      sum_in   = sum_ff;
      if (take) begin
         if (last) begin
            count_in = '0;
            peak_in  = '0;
            sum_in   = '0;
         end else begin
            count_in = count_ff + 1'b1;
            peak_in  = peak_next;
            sum_in   = sum_next;
         end
      end
   end

   assign out_valid_in = load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         out_packed_ff <= peak_next[PACKED_W-1:0];
         out_index_ff  <= peak_next[INDEX_W-1:0];
         out_sum_ff    <= sum_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_peak_packed = out_packed_ff;
   assign rsp_peak_index  = out_index_ff;
   assign rsp_power_sum   = $signed(out_sum_ff);

endmodule

>>> rtl/complex_power_peak_search_core.sv
// complex_power_peak_search_core: top level of the complex power peak search
// depends on cpps_pkg, cpps_power and cpps_accum
//
// usage
// - req channel: one signed I/Q sample per transaction (req_sample_i, req_sample_q),
//   valid/ready handshake
// - rsp channel: one result per BLOCK_LEN samples: packed peak (truncated power with
//   the sample index in its low 11 bits), the peak index and the wrapping sum of
//   power shifted right by 8
// - throughput: one sample per cycle unless req is stalled, set by the three-stage
//   power pipeline (input register, squaring multipliers, power adder) feeding the
//   accumulator
// - result path: power stages, then the accumulator's result register drives rsp
// - reset: synchronous, clears the pipeline valids, the counter, peak and sum and the
//   result valid; samples are taken in the cycle after reset
// - receiver stall: a waiting result stays on rsp until taken; samples keep flowing
//   until the last sample of the next block reaches the accumulator, then the whole
//   pipeline and req stall until the old result is taken
module complex_power_peak_search_core
   import cpps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_i,
   input  logic signed [SAMPLE_W-1:0] req_sample_q,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PACKED_W-1:0]       rsp_peak_packed,
   output logic [INDEX_W-1:0]        rsp_peak_index,
   output logic signed [POWER_W-1:0] rsp_power_sum
);

   logic             advance;
   logic             pw_valid;
   power_type        pw;
   accum_status_type status;

   // the whole pipeline moves unless the end of block is blocked
   assign advance   = !status.hold;
   assign req_ready = advance;

   cpps_power u_power (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_i     (req_sample_i),
      .in_q     (req_sample_q),
      .pw_valid (pw_valid),
      .pw       (pw)
   );

   cpps_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .pw_valid        (pw_valid),
      .pw              (pw),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_peak_packed (rsp_peak_packed),
      .rsp_peak_index  (rsp_peak_index),
      .rsp_power_sum   (rsp_power_sum)
   );

endmodule

>>> tb/peak_tracker_pkg.sv
`timescale 1ns / 100ps
// peak_tracker_pkg: block-by-block prediction of peak and power sum, and the result checker
// depends on cpps_pkg for widths, block length and the sum shift
package peak_tracker_pkg;
   import cpps_pkg::*;

   // one end-of-block result as it appears on the rsp channel
   typedef struct packed {
      logic [PACKED_W-1:0]       peak_packed;
      logic [INDEX_W-1:0]        peak_index;
      logic signed [POWER_W-1:0] power_sum;
   } block_report_type;

   class block_peak_tracker;
      int unsigned      sample_count = 0;
      power_type        running_peak = '0;
      power_type        running_sum  = '0;
      block_report_type reports_due[$];
      int               errors = 0;

      // fold one accepted sample into the current block
      function void note_sample(sample_type si, sample_type sq);
         logic signed [POWER_W-1:0] wide_i;
         logic signed [POWER_W-1:0] wide_q;
         logic signed [POWER_W-1:0] scaled;
         power_type                 power;
         power_type                 packed_word;
         block_report_type          report;
         wide_i = si;
         wide_q = sq;
         // 32-bit wrapping power, so two full-scale negatives give -2^31
         power = wide_i * wide_i + wide_q * wide_q;
         packed_word = {power[POWER_W-1:INDEX_W], INDEX_W'(sample_count)};
         // signed maximum, ties go to the later index
         if ($signed(packed_word) >= $signed(running_peak)) begin
            running_peak = packed_word;
         end
         scaled = $signed(power) >>> SUM_SHIFT;
         running_sum = running_sum + scaled;
         sample_count++;
         if (sample_count == BLOCK_LEN) begin
            report.peak_packed = running_peak[PACKED_W-1:0];
            report.peak_index  = running_peak[INDEX_W-1:0];
            report.power_sum   = running_sum;
            reports_due.push_back(report);
            sample_count = 0;
            running_peak = '0;
            running_sum  = '0;
         end
      endfunction

      // compare one rsp transaction with the oldest block still due
      function void check_result(logic [PACKED_W-1:0] got_packed,
                                 logic [INDEX_W-1:0] got_index,
                                 logic signed [POWER_W-1:0] got_sum);
         block_report_type due;
         if (reports_due.size() == 0) begin
            $error("rsp transaction with no block due: peak_packed %0h", got_packed);
            errors++;
         end else begin
            due = reports_due.pop_front();
            if (got_packed !== due.peak_packed) begin
               $error("peak_packed: expected %0h, actual %0h", due.peak_packed, got_packed);
               errors++;
            end
            if (got_index !== due.peak_index) begin
               $error("peak_index: expected %0d, actual %0d", due.peak_index, got_index);
               errors++;
            end
            if (got_sum !== due.power_sum) begin
               $error("power_sum: expected %0d, actual %0d", due.power_sum, got_sum);
               errors++;
            end
         end
      endfunction

      function int pending();
         return reports_due.size();
      endfunction

      function int unsigned block_fill();
         return sample_count;
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives I/Q samples into complex_power_peak_search_core and checks each block result
// depends on cpps_pkg, peak_tracker_pkg and the core itself
module tb_top;
   import cpps_pkg::*;
   import peak_tracker_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          BLOCKS_PER_PHASE = 9;
   localparam int          HOLD_OFF_CYCLES = 3000;

   // content styles for a whole block of samples
   typedef enum int {
      BLK_UNIFORM,
      BLK_EXTREME,
      BLK_LOW_POWER,
      BLK_FLAT,
      BLK_WRAPPED
   } block_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sample_type                req_sample_i = '0;
   sample_type                req_sample_q = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PACKED_W-1:0]       rsp_peak_packed;
   logic [INDEX_W-1:0]        rsp_peak_index;
   logic signed [POWER_W-1:0] rsp_power_sum;

   block_peak_tracker tracker;
   int unsigned       send_idle_pct = 0;
   int unsigned       rsp_stall_pct = 0;
   int                rsp_hold_left = 0;
   int unsigned       cycle_count = 0;
   sample_type        flat_i;
   sample_type        flat_q;

   // corner samples: full scale, wrapped power, truncation edge, ties
   sample_type corner_i [25] = '{0, -32768, 32767, -32768, 32767, -32768, 0, 1, 0, -1,
                                 32, 46, 181, -32768, 23170, -23170, 32767, -1, 16384,
                                 -16384, 2, -2, 12345, -32767, 0};
   sample_type corner_q [25] = '{0, -32768, 32767, 32767, -32768, 0, -32768, 0, 1, -1,
                                 0, 0, 181, 1, 23170, 23170, 0, 32767, 16384,
                                 -16384, -2, 2, -12345, -32767, -32768};
   sample_type edge_vals [9] = '{-32768, -32767, -16384, -1, 0, 1, 16383, 32766, 32767};
   int unsigned phase_send_idle [4] = '{0, 49, 0, 7};
   int unsigned phase_rsp_stall [4] = '{0, 0, 49, 7};

   complex_power_peak_search_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_peak_packed (rsp_peak_packed),
      .rsp_peak_index  (rsp_peak_index),
      .rsp_power_sum   (rsp_power_sum)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // one req transaction; entered and left just after a falling edge
   task automatic send_sample(sample_type si, sample_type sq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      do @(posedge clock); while (!req_ready);
      tracker.note_sample(si, sq);
      @(negedge clock);
   endtask

   // sample content for the given block style
   task automatic draw_sample(block_kind_type kind, output sample_type si,
                              output sample_type sq);
      case (kind)
         BLK_EXTREME: begin
            si = $urandom_range(1) ? edge_vals[$urandom_range(8)] : sample_type'($urandom);
            sq = $urandom_range(1) ? edge_vals[$urandom_range(8)] : sample_type'($urandom);
         end
         BLK_LOW_POWER: begin
            si = sample_type'(int'($urandom_range(127)) - 64);
            sq = sample_type'(int'($urandom_range(127)) - 64);
         end
         BLK_FLAT: begin
            // mostly one repeated sample so the truncated power ties
            if ($urandom_range(15) == 0) begin
               si = sample_type'(int'($urandom_range(7)) - 4);
               sq = sample_type'(int'($urandom_range(7)) - 4);
            end else begin
               si = flat_i;
               sq = flat_q;
            end
         end
         BLK_WRAPPED: begin
            si = sample_type'(-32768);
            sq = sample_type'(-32768);
         end
         default: begin
            si = sample_type'($urandom);
            sq = sample_type'($urandom);
         end
      endcase
   endtask

   // result side: random stalls plus an optional long hold-off
   initial begin
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_peak_packed, rsp_peak_index, rsp_power_sum);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      sample_type     si;
      sample_type     sq;
      block_kind_type kind;
      tracker = new;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      foreach (corner_i[n]) begin
         send_sample(corner_i[n], corner_q[n]);
      end
      // complete the first block with uniform samples
      while (tracker.block_fill() != 0) begin
         draw_sample(BLK_UNIFORM, si, sq);
         send_sample(si, sq);
      end

      // random blocks under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase_send_idle[phase];
         rsp_stall_pct = phase_rsp_stall[phase];
         // long receiver hold-off so the next block backs up into req
         if (phase == 0) begin
            rsp_hold_left = HOLD_OFF_CYCLES;
         end
         for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            kind   = block_kind_type'((phase * BLOCKS_PER_PHASE + blk) % 5);
            flat_i = sample_type'($urandom);
            flat_q = sample_type'($urandom);
            repeat (BLOCK_LEN) begin
               draw_sample(kind, si, sq);
               send_sample(si, sq);
            end
         end
      end
      req_valid <= 1'b0;

      // drain outstanding blocks, then allow for the output latency
      while (tracker.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
